// File: design/frequency_order_item_sorter_macros.svh
// Assertion macros used by the sorter top-level RTL file
`ifndef FREQUENCY_ORDER_ITEM_SORTER_MACROS_SVH
`define FREQUENCY_ORDER_ITEM_SORTER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FOIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication, checked out of reset
`define FOIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed");

`endif

// File: design/fois_pkg.sv
// Shared types, sizes and key compare for the frequency-order sorter
`default_nettype none

package fois_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int ID_W      = 20;
    localparam int CNT_W     = 32;
    localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_ITEMS);

    // One stored entry of the chain
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Chain-wide control, the same for every cell
    typedef struct packed {
        logic load;    // insert the broadcast request
        logic unload;  // shift one place towards the head
    } t_cell_ctl;

    // True when key a must sit strictly ahead of key b:
    // higher count first, then lower id
    function automatic logic goes_before(
        input logic [CNT_W-1:0] count_a,
        input logic [ID_W-1:0]  id_a,
        input logic [CNT_W-1:0] count_b,
        input logic [ID_W-1:0]  id_b
    );
        logic res;
        if (count_a != count_b) begin
            res = (count_a > count_b);
        end else begin
            res = (id_a < id_b);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/fois_cell.sv
// One insertion cell of the sorting chain
`default_nettype none

module fois_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fois_pkg::t_cell_ctl i_ctl,
    input  wire fois_pkg::t_entry   i_new,
    input  wire fois_pkg::t_entry   i_left,
    input  wire logic               i_left_ins,
    input  wire fois_pkg::t_entry   i_right,
    output fois_pkg::t_entry        o_entry,
    output logic                    o_ins
);
    import fois_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   ins;

    // New request belongs at or ahead of this cell
    always_comb begin
        ins = !r_entry.valid ||
              goes_before(i_new.count, i_new.id, r_entry.count, r_entry.id);
    end

    // Insert: first cell to take it grabs the request, the rest take the
    // left neighbour; unload: take the right neighbour
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            if (ins) begin
                n_entry = i_left_ins ? i_left : i_new;
            end
        end else if (i_ctl.unload) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_ins   = ins;

endmodule

`default_nettype wire

// File: design/frequency_order_item_sorter.sv
// Top level of the frequency-order item sorter: control and cell chain
//
// Usage:
//   Items of one transaction enter on i_item_id / i_item_count / i_last_item;
//   a request is taken at a rising edge with start high and busy low.
//   Each request is placed into the chain of MAX_ITEMS insertion cells as it
//   is taken, so non-final items can follow back to back at one per cycle.
//   The chain keeps entries ordered by descending count, then ascending id.
//   Once the request with i_last_item set is taken, busy rises and the chain
//   shifts one entry per cycle towards its head; the head entry is shown on
//   the o_sorted_* ports with o_result_strobe for exactly one cycle.
//   The first result is registered from the chain head once in ST_EMIT;
//   N stored entries give N results on consecutive cycles, with busy high
//   until the final one is registered. No request is taken while busy; the
//   unload rate is set by the single shift path out of the chain head.
//   o_end_of_run marks the final result; o_overflow is set on every result
//   of a transaction that met a full chain (those items are dropped).
//   Synchronous reset empties the chain and clears fill count and drop flag;
//   no clearing pass is needed. Results cannot be held off by the receiver.
`default_nettype none
`include "frequency_order_item_sorter_macros.svh"

module frequency_order_item_sorter (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [fois_pkg::ID_W-1:0]  i_item_id,
    input  wire logic [fois_pkg::CNT_W-1:0] i_item_count,
    input  wire logic                       i_last_item,
    output logic                            o_result_strobe,
    output logic [fois_pkg::ID_W-1:0]       o_sorted_id,
    output logic [fois_pkg::CNT_W-1:0]      o_sorted_count,
    output logic                            o_end_of_run,
    output logic                            o_overflow
);
    import fois_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state            r_state;
    logic [FILL_W-1:0] r_fill;
    logic              r_dropped;

    logic      accept;
    logic      full;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_entry    empty_entry;
    t_entry    cell_q   [MAX_ITEMS];
    logic      cell_ins [MAX_ITEMS];

    assign busy   = (r_state == ST_EMIT);
    assign accept = start && !busy;
    assign full   = (r_fill == MAX_FILL);

    // Chain control and broadcast request
    always_comb begin
        ctl.load   = accept && !full;
        ctl.unload = busy;
        new_entry.valid = 1'b1;
        new_entry.count = i_item_count;
        new_entry.id    = i_item_id;
        empty_entry     = '0;
    end

    // Row of insertion cells, head at index 0
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_ins;

        if (g == 0) begin : g_head
            assign left_e   = empty_entry;
            assign left_ins = 1'b0;
        end else begin : g_body
            assign left_e   = cell_q[g-1];
            assign left_ins = cell_ins[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right_e = empty_entry;
        end else begin : g_inner
            assign right_e = cell_q[g+1];
        end

        fois_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_new      (new_entry),
            .i_left     (left_e),
            .i_left_ins (left_ins),
            .i_right    (right_e),
            .o_entry    (cell_q[g]),
            .o_ins      (cell_ins[g])
        );
    end

    // Sequencer: fill count, drop flag, unload and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_fill          <= '0;
            r_dropped       <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                        end
                        if (i_last_item) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    o_result_strobe <= 1'b1;
                    o_sorted_id     <= cell_q[0].id;
                    o_sorted_count  <= cell_q[0].count;
                    o_end_of_run    <= (r_fill == FILL_W'(1));
                    o_overflow      <= r_dropped;
                    r_fill          <= r_fill - 1'b1;
                    if (r_fill == FILL_W'(1)) begin
                        r_state   <= ST_IDLE;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `FOIS_ASSERT_NOW(a_emit_has_entry, i_clk, i_rst_n, busy, (r_fill != '0) && cell_q[0].valid)
    `FOIS_ASSERT_NOW(a_end_frees, i_clk, i_rst_n, o_result_strobe && o_end_of_run, !busy)
    `FOIS_ASSERT_NOW(a_strobe_from_emit, i_clk, i_rst_n, o_result_strobe, $past(busy))
    `FOIS_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, accept && !full && !i_last_item, r_fill == $past(r_fill) + 1'b1)
    `FOIS_ASSERT_NEXT(a_full_drops, i_clk, i_rst_n, accept && full, r_dropped || (o_result_strobe && o_overflow))

endmodule

`default_nettype wire
